// File: sv/rle_four_plus_count_encoder_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef RLE_FOUR_PLUS_COUNT_ENCODER_MACROS_SVH
`define RLE_FOUR_PLUS_COUNT_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLE4_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rle4 implication check failed");

// Next-cycle implication, checked outside reset.
`define RLE4_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rle4 next-cycle check failed");

`endif

// File: sv/rle4_pkg.sv
// Package: types and constants of the run-length encoder.
`timescale 1ns / 1ps
`default_nettype none
package rle4_pkg;

  localparam int MAX_RUN_DEFAULT     = 255;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [7:0] RUN_MIN     = 8'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_count;
    logic       run_last;
    logic       block_last;
  } out_item_t;

  // One classified input: one or two result bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic       cnt0;
    logic [7:0] byte1;
    logic       cnt1;
    logic       two;
    logic       last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// File: sv/rle4_front.sv
// Front end: run tracking and classification of each accepted byte.
`timescale 1ns / 1ps
`default_nettype none
module rle4_front #(
  parameter int MAX_RUN = rle4_pkg::MAX_RUN_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire rle4_pkg::in_item_t item,
  output logic                   op_push,
  output rle4_pkg::op_t          op
);
  import rle4_pkg::*;
  `include "rle_four_plus_count_encoder_macros.svh"

  logic [7:0] run_symbol;
  logic [7:0] run_length;
  logic [7:0] run_symbol_next;
  logic [7:0] run_length_next;
  logic [7:0] len_inc;
  logic [7:0] len_mid;
  logic       match;
  logic [1:0] n_mid;
  logic [1:0] n_out;

  assign match   = (run_length != 8'd0) && (item.data_byte == run_symbol);
  assign len_inc = run_length + 8'd1;

  always_comb begin
    op              = '0;
    n_mid           = 2'd0;
    len_mid         = run_length;
    run_symbol_next = run_symbol;
    if (match) begin
      if (len_inc <= RUN_MIN) begin
        op.byte0 = item.data_byte;
        n_mid    = 2'd1;
        len_mid  = len_inc;
      end else if (len_inc >= 8'(MAX_RUN)) begin
        // chunk full: close it with its count
        op.byte0 = len_inc - RUN_MIN;
        op.cnt0  = 1'b1;
        n_mid    = 2'd1;
        len_mid  = 8'd0;
      end else begin
        len_mid = len_inc;
      end
    end else begin
      run_symbol_next = item.data_byte;
      len_mid         = 8'd1;
      if (run_length >= RUN_MIN) begin
        op.byte0 = run_length - RUN_MIN;
        op.cnt0  = 1'b1;
        op.byte1 = item.data_byte;
        n_mid    = 2'd2;
      end else begin
        op.byte0 = item.data_byte;
        n_mid    = 2'd1;
      end
    end

    // flush an owed count at block end
    n_out           = n_mid;
    run_length_next = len_mid;
    if (item.block_end) begin
      if (len_mid >= RUN_MIN) begin
        if (n_mid == 2'd0) begin
          op.byte0 = len_mid - RUN_MIN;
          op.cnt0  = 1'b1;
          n_out    = 2'd1;
        end else begin
          op.byte1 = len_mid - RUN_MIN;
          op.cnt1  = 1'b1;
          n_out    = 2'd2;
        end
      end
      run_length_next = 8'd0;
    end

    op.two  = (n_out == 2'd2);
    op.last = item.block_end;
    op_push = accept && (n_out != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= 8'd0;
      run_length <= 8'd0;
    end else if (accept) begin
      run_symbol <= run_symbol_next;
      run_length <= run_length_next;
    end
  end

  `RLE4_ASSERT_IMPL(a_len_below_max, clk, rst, 1'b1, run_length < 8'(MAX_RUN))
  `RLE4_ASSERT_IMPL(a_end_pushes, clk, rst, accept && item.block_end, op_push)
  `RLE4_ASSERT_NEXT(a_end_closes, clk, rst, accept && item.block_end, run_length == 8'd0)

endmodule
`default_nettype wire

// File: sv/rle4_queue.sv
// Short queue of classified operations between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module rle4_queue #(
  parameter int DEPTH = rle4_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire rle4_pkg::op_t      push_op,
  input  wire logic               pop,
  output rle4_pkg::op_t           head,
  output rle4_pkg::q_status_t     status
);
  import rle4_pkg::*;
  `include "rle_four_plus_count_encoder_macros.svh"

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RLE4_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `RLE4_ASSERT_NEXT(a_grow, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `RLE4_ASSERT_IMPL(a_ptrs_meet, clk, rst, status.empty || status.full, wr_ptr == rd_ptr)

endmodule
`default_nettype wire

// File: sv/rle4_back.sv
// Back end: serialise each queued operation into one or two result bytes.
`timescale 1ns / 1ps
`default_nettype none
module rle4_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rle4_pkg::op_t       head,
  input  wire rle4_pkg::q_status_t status,
  input  wire logic                pop,
  output logic                     q_pop,
  output logic                     empty,
  output rle4_pkg::out_item_t      result
);
  import rle4_pkg::*;
  `include "rle_four_plus_count_encoder_macros.svh"

  logic second;
  logic take;

  assign empty = status.empty;
  assign take  = pop && !status.empty;

  always_comb begin
    result.out_byte   = second ? head.byte1 : head.byte0;
    result.is_count   = second ? head.cnt1 : head.cnt0;
    result.run_last   = second || !head.two;
    result.block_last = result.run_last && head.last;
    q_pop             = take && result.run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !result.run_last;
    end
  end

  `RLE4_ASSERT_IMPL(a_second_valid, clk, rst, second, !status.empty)
  `RLE4_ASSERT_IMPL(a_second_pair, clk, rst, second, head.two)
  `RLE4_ASSERT_NEXT(a_advance, clk, rst, take && !second && head.two, second)

endmodule
`default_nettype wire

// File: sv/rle_four_plus_count_encoder.sv
// Top level of the four-plus-count run-length encoder.
// Raw bytes enter through a queue-style port (push/full) and encoded bytes
// leave through another (empty/pop). Runs shorter than four pass through;
// a longer run gives four copies of its symbol and then a count byte equal
// to the run length minus four. A run is cut at MAX_RUN bytes, the chunk
// closing with count MAX_RUN-4 (251 by default), and block_end flushes any
// owed count. Each transaction in gives zero, one or two transactions out;
// run_last marks the last of them and block_last the final byte of a block.
// One byte is taken per cycle while the operation queue has room; the
// output side delivers one byte per cycle while pop is high and the queue
// is not empty, so the sustained rate is set by the pop side: an input
// giving two bytes takes a pop for each. Operations are registered in the
// queue before the result port; full rises when QUEUE_DEPTH operations wait.
`timescale 1ns / 1ps
`default_nettype none
module rle_four_plus_count_encoder #(
  parameter int MAX_RUN     = rle4_pkg::MAX_RUN_DEFAULT,
  parameter int QUEUE_DEPTH = rle4_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rle4_pkg::in_item_t  item,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output rle4_pkg::out_item_t      result
);
  import rle4_pkg::*;

  logic      accept;
  logic      op_push;
  op_t       op;
  op_t       head;
  logic      q_pop;
  q_status_t q_status;

  // accept a transaction only while the queue has room
  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  rle4_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .op_push (op_push),
    .op      (op)
  );

  // decouple classification from serialisation
  rle4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (op_push),
    .push_op (op),
    .pop     (q_pop),
    .head    (head),
    .status  (q_status)
  );

  rle4_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (q_status),
    .pop    (pop),
    .q_pop  (q_pop),
    .empty  (empty),
    .result (result)
  );

endmodule
`default_nettype wire
